FILE: hw/rtl/c2e_pkg.sv
package c2e_pkg;

  localparam int FracBits     = 16;
  localparam int AngleBits    = 17;
  localparam int CordicSteps  = 16;
  localparam int CordicPre    = 6;
  localparam int DivSteps     = AngleBits + 1;
  localparam int SqrtSteps    = 17;
  localparam int MaxFaceSize  = 1024;
  localparam int FaceSizeW    = 11;

  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  localparam logic signed [19:0] ANG_PI      = 20'sd131072;
  localparam logic signed [19:0] ANG_HALF_PI = 20'sd65536;

  // x/y carry the preshifted vector, z the accumulated angle (fraction of pi)
  typedef struct packed {
    logic signed [26:0] x;
    logic signed [26:0] y;
    logic signed [19:0] z;
  } cordic_st_t;

  function automatic logic signed [19:0] atan_entry(input int unsigned idx);
    logic signed [19:0] v;
    case (idx)
      0:       v = 20'sd32768;
      1:       v = 20'sd19344;
      2:       v = 20'sd10221;
      3:       v = 20'sd5188;
      4:       v = 20'sd2604;
      5:       v = 20'sd1303;
      6:       v = 20'sd652;
      7:       v = 20'sd326;
      8:       v = 20'sd163;
      9:       v = 20'sd81;
      10:      v = 20'sd41;
      11:      v = 20'sd20;
      12:      v = 20'sd10;
      13:      v = 20'sd5;
      14:      v = 20'sd3;
      15:      v = 20'sd1;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

  // Fold left half-plane into the right half before the rotations.
  function automatic cordic_st_t cordic_pre(input logic signed [17:0] y,
                                            input logic signed [17:0] x);
    cordic_st_t s;
    logic signed [26:0] xe;
    logic signed [26:0] ye;
    xe  = 27'(x) <<< CordicPre;
    ye  = 27'(y) <<< CordicPre;
    s.x = xe;
    s.y = ye;
    s.z = '0;
    if (x < 0) begin
      s.z = (y >= 0) ? ANG_PI : -ANG_PI;
      s.x = -xe;
      s.y = -ye;
    end
    return s;
  endfunction

endpackage

FILE: hw/rtl/c2e_div_cell.sv
// One restoring-division bit per cell.
module c2e_div_cell import c2e_pkg::*; (
  input  logic                 clk_i,
  input  logic [FaceSizeW-1:0] fs_i,
  input  logic [FaceSizeW-1:0] rem_i,
  input  logic [DivSteps-1:0]  nq_i,
  output logic [FaceSizeW-1:0] rem_o,
  output logic [DivSteps-1:0]  nq_o
);

  logic [FaceSizeW:0]   trial;
  logic                 ge;
  logic [FaceSizeW-1:0] rem_d, rem_q;
  logic [DivSteps-1:0]  nq_d, nq_q;

  always_comb begin
    trial = {rem_i, nq_i[DivSteps-1]};
    ge    = trial >= {1'b0, fs_i};
    rem_d = ge ? FaceSizeW'(trial - {1'b0, fs_i}) : trial[FaceSizeW-1:0];
    nq_d  = {nq_i[DivSteps-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    nq_q  <= nq_d;
  end

  assign rem_o = rem_q;
  assign nq_o  = nq_q;

endmodule

FILE: hw/rtl/c2e_sqrt_cell.sv
// One root bit per cell (digit-by-digit floor square root).
module c2e_sqrt_cell import c2e_pkg::*; (
  input  logic                   clk_i,
  input  logic [SqrtSteps+1:0]   rem_i,
  input  logic [SqrtSteps-1:0]   root_i,
  input  logic [2*SqrtSteps-1:0] rad_i,
  output logic [SqrtSteps+1:0]   rem_o,
  output logic [SqrtSteps-1:0]   root_o,
  output logic [2*SqrtSteps-1:0] rad_o
);

  logic [SqrtSteps+3:0]   cur;
  logic [SqrtSteps+3:0]   trial;
  logic                   ge;
  logic [SqrtSteps+1:0]   rem_d, rem_q;
  logic [SqrtSteps-1:0]   root_d, root_q;
  logic [2*SqrtSteps-1:0] rad_d, rad_q;

  always_comb begin
    cur    = {rem_i, rad_i[2*SqrtSteps-1 -: 2]};
    trial  = {2'b00, root_i, 2'b01};
    ge     = cur >= trial;
    rem_d  = ge ? (SqrtSteps+2)'(cur - trial) : cur[SqrtSteps+1:0];
    root_d = {root_i[SqrtSteps-2:0], ge};
    rad_d  = {rad_i[2*SqrtSteps-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    rad_q  <= rad_d;
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign rad_o  = rad_q;

endmodule

FILE: hw/rtl/c2e_cordic_cell.sv
// One vectoring CORDIC micro-rotation.
module c2e_cordic_cell import c2e_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic       clk_i,
  input  cordic_st_t st_i,
  output cordic_st_t st_o
);

  localparam logic signed [19:0] Atan = atan_entry(STEP);

  logic signed [26:0] xs;
  logic signed [26:0] ys;
  cordic_st_t         st_d, st_q;

  always_comb begin
    xs = st_i.x >>> STEP;
    ys = st_i.y >>> STEP;
    if (st_i.y >= 0) begin
      st_d.x = st_i.x + ys;
      st_d.y = st_i.y - xs;
      st_d.z = st_i.z + Atan;
    end else begin
      st_d.x = st_i.x - ys;
      st_d.y = st_i.y + xs;
      st_d.z = st_i.z - Atan;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign st_o = st_q;

endmodule

FILE: hw/rtl/cube_face_to_equirect_sample_coords_unit.sv
// Cube-face pixel to equirectangular sample coordinates. A request (face,
// col, row) is taken at every clock edge where start is high; busy never
// rises, so one request per clock is sustained. Each request yields exactly
// one result, shown for a single cycle with done_o high. The pipeline is
// the cell chains in series: an 18-cell divider per coordinate, a 17-cell
// square-root chain and two 16-cell CORDIC chains running side by side,
// plus glue stages. The receiver cannot stall, so there is no back-pressure
// anywhere in the pipeline. The edge-length register must only be written
// while no request is in flight.
module cube_face_to_equirect_sample_coords_unit import c2e_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  face_i,
  input  logic [9:0]  col_i,
  input  logic [9:0]  row_i,
  // result
  output logic        done_o,
  output logic [11:0] dest_x_o,
  output logic [11:0] dest_y_o,
  output logic [11:0] src_u0_o,
  output logic [10:0] src_v0_o,
  output logic [11:0] src_u1_o,
  output logic [10:0] src_v1_o,
  output logic [16:0] frac_s_o,
  output logic [16:0] frac_t_o
);

  // Stage map (register index of valid pipe):
  //   0        input capture, face offsets, col/row clamp
  //   1..18    divider cells -> a, b
  //   19       direction vector
  //   20       squares
  //   21       radicand
  //   22..38   square-root cells -> pd
  //   39       CORDIC fold (theta and phi)
  //   40..55   CORDIC cells
  //   56       angle clamp and scale multiply
  //   57       floor, clamp, weights -> result
  localparam int Latency  = 58;
  localparam int FaceDly  = DivSteps;        // stage 1..18
  localparam int DirDly   = 2 + SqrtSteps;   // stage 20..38
  localparam int ZeroDly  = CordicSteps + 1; // stage 39..55
  localparam int DestDly  = Latency - 2;     // stage 1..56

  // ---------------- configuration ----------------
  logic [FaceSizeW-1:0] fs_q, fs_d;
  logic [FaceSizeW-1:0] fs;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {21'b0, fs_q} : 32'b0;

  always_comb begin
    fs_d = fs_q;
    if (cfg_wr) begin
      fs_d = pwdata[FaceSizeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= FaceSizeW'(256);
    end else begin
      fs_q <= fs_d;
    end
  end

  // zero acts as one, oversize as the maximum
  always_comb begin
    fs = fs_q;
    if (fs_q == '0) begin
      fs = FaceSizeW'(1);
    end else if (fs_q > FaceSizeW'(MaxFaceSize)) begin
      fs = FaceSizeW'(MaxFaceSize);
    end
  end

  // ---------------- valid pipe ----------------
  logic [Latency-1:0] vld_q, vld_d;

  assign busy  = 1'b0;
  assign vld_d = {vld_q[Latency-2:0], start};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // ---------------- stage 0 ----------------
  logic [11:0]          offx, offy;
  logic [10:0]          colc, rowc;
  logic [10:0]          colc_q, rowc_q;
  logic [2:0]           face_q;
  logic [23:0]          dest_q;

  always_comb begin
    unique case (face_i)
      FACE_PX: begin offx = {fs, 1'b0};    offy = 12'(fs); end
      FACE_NX: begin offx = '0;            offy = 12'(fs); end
      FACE_PY: begin offx = 12'(fs);       offy = '0; end
      FACE_NY: begin offx = 12'(fs);       offy = {fs, 1'b0}; end
      FACE_PZ: begin offx = 12'(fs);       offy = 12'(fs) + {fs, 1'b0}; end
      FACE_NZ: begin offx = 12'(fs);       offy = 12'(fs); end
      default: begin offx = '0;            offy = '0; end
    endcase
    // past the edge the unit coordinate saturates at 2.0: col = fs gives that
    colc = ({1'b0, col_i} > fs) ? fs : {1'b0, col_i};
    rowc = ({1'b0, row_i} > fs) ? fs : {1'b0, row_i};
  end

  always_ff @(posedge clk_i) begin
    colc_q <= colc;
    rowc_q <= rowc;
    face_q <= face_i;
    dest_q <= {offx + 12'(col_i), offy + 12'(row_i)};
  end

  // ---------------- side delay lines ----------------
  logic [2:0]  face_dly_q [FaceDly];
  logic [23:0] dest_dly_q [DestDly];

  always_ff @(posedge clk_i) begin
    face_dly_q[0] <= face_q;
    for (int k = 1; k < FaceDly; k++) begin
      face_dly_q[k] <= face_dly_q[k-1];
    end
    dest_dly_q[0] <= dest_q;
    for (int k = 1; k < DestDly; k++) begin
      dest_dly_q[k] <= dest_dly_q[k-1];
    end
  end

  // ---------------- dividers: a = col*2^17/fs ----------------
  logic [FaceSizeW-1:0] ca_rem [DivSteps+1];
  logic [DivSteps-1:0]  ca_nq  [DivSteps+1];
  logic [FaceSizeW-1:0] cb_rem [DivSteps+1];
  logic [DivSteps-1:0]  cb_nq  [DivSteps+1];

  assign ca_rem[0] = {1'b0, colc_q[10:1]};
  assign ca_nq[0]  = {colc_q[0], {(DivSteps-1){1'b0}}};
  assign cb_rem[0] = {1'b0, rowc_q[10:1]};
  assign cb_nq[0]  = {rowc_q[0], {(DivSteps-1){1'b0}}};

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    c2e_div_cell u_div_a (
      .clk_i (clk_i),
      .fs_i  (fs),
      .rem_i (ca_rem[g]),
      .nq_i  (ca_nq[g]),
      .rem_o (ca_rem[g+1]),
      .nq_o  (ca_nq[g+1])
    );
    c2e_div_cell u_div_b (
      .clk_i (clk_i),
      .fs_i  (fs),
      .rem_i (cb_rem[g]),
      .nq_i  (cb_nq[g]),
      .rem_o (cb_rem[g+1]),
      .nq_o  (cb_nq[g+1])
    );
  end

  // ---------------- stage 19: direction ----------------
  logic signed [18:0] am1_w, bm1_w;
  logic signed [17:0] am1, bm1;
  logic signed [17:0] dx, dy, dz;
  logic signed [17:0] dx_q, dy_q, dz_q;
  localparam logic signed [17:0] One = 18'sd65536;

  always_comb begin
    am1_w = $signed({1'b0, ca_nq[DivSteps]}) - 19'sd65536;
    bm1_w = $signed({1'b0, cb_nq[DivSteps]}) - 19'sd65536;
    am1   = am1_w[17:0];
    bm1   = bm1_w[17:0];
    unique case (face_dly_q[FaceDly-1])
      FACE_PX: begin dx = -am1; dy = One;  dz = -bm1; end
      FACE_NX: begin dx = am1;  dy = -One; dz = -bm1; end
      FACE_PY: begin dx = bm1;  dy = am1;  dz = One;  end
      FACE_NY: begin dx = -bm1; dy = am1;  dz = -One; end
      FACE_PZ: begin dx = -One; dy = am1;  dz = bm1;  end
      FACE_NZ: begin dx = One;  dy = am1;  dz = -bm1; end
      default: begin dx = '0;   dy = '0;   dz = '0;   end
    endcase
  end

  always_ff @(posedge clk_i) begin
    dx_q <= dx;
    dy_q <= dy;
    dz_q <= dz;
  end

  // dx, dy, dz ride along to the CORDIC fold
  logic signed [17:0] dx_dly_q [DirDly];
  logic signed [17:0] dy_dly_q [DirDly];
  logic signed [17:0] dz_dly_q [DirDly];

  always_ff @(posedge clk_i) begin
    dx_dly_q[0] <= dx_q;
    dy_dly_q[0] <= dy_q;
    dz_dly_q[0] <= dz_q;
    for (int k = 1; k < DirDly; k++) begin
      dx_dly_q[k] <= dx_dly_q[k-1];
      dy_dly_q[k] <= dy_dly_q[k-1];
      dz_dly_q[k] <= dz_dly_q[k-1];
    end
  end

  // ---------------- stages 20, 21: dx^2 + dy^2 ----------------
  logic signed [35:0] sqx_w, sqy_w;
  logic [2*SqrtSteps-1:0] sqx_q, sqy_q, rad_q;

  assign sqx_w = dx_q * dx_q;
  assign sqy_w = dy_q * dy_q;

  always_ff @(posedge clk_i) begin
    sqx_q <= sqx_w[2*SqrtSteps-1:0];
    sqy_q <= sqy_w[2*SqrtSteps-1:0];
    rad_q <= sqx_q + sqy_q;
  end

  // ---------------- square-root chain ----------------
  logic [SqrtSteps+1:0]   sq_rem  [SqrtSteps+1];
  logic [SqrtSteps-1:0]   sq_root [SqrtSteps+1];
  logic [2*SqrtSteps-1:0] sq_rad  [SqrtSteps+1];

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = rad_q;

  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
    c2e_sqrt_cell u_sqrt (
      .clk_i  (clk_i),
      .rem_i  (sq_rem[g]),
      .root_i (sq_root[g]),
      .rad_i  (sq_rad[g]),
      .rem_o  (sq_rem[g+1]),
      .root_o (sq_root[g+1]),
      .rad_o  (sq_rad[g+1])
    );
  end

  // ---------------- stage 39: CORDIC fold ----------------
  logic signed [17:0] pd;
  logic               zth, zph;
  cordic_st_t         th_st [CordicSteps+1];
  cordic_st_t         ph_st [CordicSteps+1];
  cordic_st_t         th_pre_q, ph_pre_q;
  logic [1:0]         zero_dly_q [ZeroDly];

  assign pd  = $signed({1'b0, sq_root[SqrtSteps]});
  // atan2 of the zero vector is zero
  assign zth = (dx_dly_q[DirDly-1] == '0) && (dy_dly_q[DirDly-1] == '0);
  assign zph = (pd == '0) && (dz_dly_q[DirDly-1] == '0);

  always_ff @(posedge clk_i) begin
    th_pre_q      <= cordic_pre(dy_dly_q[DirDly-1], dx_dly_q[DirDly-1]);
    ph_pre_q      <= cordic_pre(dz_dly_q[DirDly-1], pd);
    zero_dly_q[0] <= {zph, zth};
    for (int k = 1; k < ZeroDly; k++) begin
      zero_dly_q[k] <= zero_dly_q[k-1];
    end
  end

  assign th_st[0] = th_pre_q;
  assign ph_st[0] = ph_pre_q;

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cordic
    c2e_cordic_cell #(.STEP(g)) u_th (
      .clk_i (clk_i),
      .st_i  (th_st[g]),
      .st_o  (th_st[g+1])
    );
    c2e_cordic_cell #(.STEP(g)) u_ph (
      .clk_i (clk_i),
      .st_i  (ph_st[g]),
      .st_o  (ph_st[g+1])
    );
  end

  // ---------------- stage 56: clamp and scale ----------------
  logic signed [19:0] th, ph, tp_w, vp_w;
  logic [11:0]        fs2;
  logic [29:0]        uq_q;  // up to 2^29
  logic [28:0]        vq_q;  // up to 2^28

  always_comb begin
    th = zero_dly_q[ZeroDly-1][0] ? '0 : th_st[CordicSteps].z;
    ph = zero_dly_q[ZeroDly-1][1] ? '0 : ph_st[CordicSteps].z;
    if (th > ANG_PI) th = ANG_PI;
    if (th < -ANG_PI) th = -ANG_PI;
    if (ph > ANG_HALF_PI) ph = ANG_HALF_PI;
    if (ph < -ANG_HALF_PI) ph = -ANG_HALF_PI;
    tp_w = th + ANG_PI;          // 0 .. 2^18
    vp_w = ANG_HALF_PI - ph;     // 0 .. 2^17
    fs2  = {fs, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    uq_q <= 30'(fs2) * 30'(tp_w[18:0]);
    vq_q <= 29'(fs2) * 29'(vp_w[17:0]);
  end

  // ---------------- stage 57: floor, neighbors, weights ----------------
  logic [12:0] umax, u0r, u0c, u1c;
  logic [11:0] vmax, v0r, v0c, v1c;
  logic [29:0] udiff;
  logic [28:0] vdiff;

  logic [11:0] dest_x_q, dest_y_q, u0_q, u1_q;
  logic [10:0] v0_q, v1_q;
  logic [16:0] fs_frac_q, ft_frac_q;

  always_comb begin
    umax  = {fs, 2'b00} - 13'd1;
    vmax  = {fs, 1'b0} - 12'd1;
    u0r   = uq_q[29:AngleBits];
    v0r   = vq_q[28:AngleBits];
    u0c   = (u0r > umax) ? umax : u0r;
    v0c   = (v0r > vmax) ? vmax : v0r;
    u1c   = (u0c + 13'd1 > umax) ? umax : u0c + 13'd1;
    v1c   = (v0c + 12'd1 > vmax) ? vmax : v0c + 12'd1;
    udiff = uq_q - {u0c, {AngleBits{1'b0}}};
    vdiff = vq_q - {v0c, {AngleBits{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    dest_x_q  <= dest_dly_q[DestDly-1][23:12];
    dest_y_q  <= dest_dly_q[DestDly-1][11:0];
    u0_q      <= u0c[11:0];
    u1_q      <= u1c[11:0];
    v0_q      <= v0c[10:0];
    v1_q      <= v1c[10:0];
    fs_frac_q <= udiff[AngleBits:AngleBits-FracBits];
    ft_frac_q <= vdiff[AngleBits:AngleBits-FracBits];
  end

  assign done_o   = vld_q[Latency-1];
  assign dest_x_o = dest_x_q;
  assign dest_y_o = dest_y_q;
  assign src_u0_o = u0_q;
  assign src_v0_o = v0_q;
  assign src_u1_o = u1_q;
  assign src_v1_o = v1_q;
  assign frac_s_o = fs_frac_q;
  assign frac_t_o = ft_frac_q;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import c2e_pkg::*;

  localparam logic [2:0] REG_EDGE_LEN = 3'd0;   // byte address of the edge-length register
  localparam int PIPE_DRAIN = 80;                // longer than the pipeline latency
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [11:0] u0;
    logic [10:0] v0;
    logic [11:0] u1;
    logic [10:0] v1;
    logic [16:0] fs;
    logic [16:0] ft;
  } sample_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [2:0] face_i = '0;
  logic [9:0] col_i = '0, row_i = '0;
  logic done_o;
  logic [11:0] dest_x_o, dest_y_o, src_u0_o, src_u1_o;
  logic [10:0] src_v0_o, src_v1_o;
  logic [16:0] frac_s_o, frac_t_o;

  cube_face_to_equirect_sample_coords_unit u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .face_i, .col_i, .row_i, .done_o, .dest_x_o, .dest_y_o,
    .src_u0_o, .src_v0_o, .src_u1_o, .src_v1_o, .frac_s_o, .frac_t_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // model copy of the edge-length register
  logic [10:0] edge_len = 11'd256;
  sample_t pending_samples[$];
  int unsigned n_accepted = 0;
  int unsigned n_fail = 0;
  bit no_idle = 1'b0;
  longint cycles = 0;

  // ---------------------------------------------------------------------------
  // Predictor: fixed-point direction, CORDIC angles, equirect scaling
  // ---------------------------------------------------------------------------
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // atan2 as a signed fraction of pi, AngleBits fraction bits
  function automatic longint vec_angle(input longint y, input longint x);
    longint z, nx, ny;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * (64'sd1 <<< CordicPre);
    y = y * (64'sd1 <<< CordicPre);
    if (x < 0) begin
      z = (y >= 0) ? (64'sd1 <<< AngleBits) : -(64'sd1 <<< AngleBits);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += longint'(atan_entry(i));
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= longint'(atan_entry(i));
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic longint norm_coord(input longint p, input longint f);
    longint a;
    a = ((2 * p) <<< FracBits) / f;
    return (a > (64'sd2 <<< FracBits)) ? (64'sd2 <<< FracBits) : a;
  endfunction

  function automatic sample_t predict_sample(input logic [2:0] fc, input logic [9:0] c,
                                             input logic [9:0] r, input logic [10:0] reg_f);
    sample_t s;
    longint f, a, b, dx, dy, dz, offx, offy, pd, th, ph, uq, vq, u0, v0, u1, v1;
    longint one, pi;
    one = 64'sd1 <<< FracBits;
    pi = 64'sd1 <<< AngleBits;
    f = reg_f;
    if (f == 0) f = 1;
    if (f > MaxFaceSize) f = MaxFaceSize;
    a = norm_coord(c, f);
    b = norm_coord(r, f);
    dx = 0; dy = 0; dz = 0; offx = 0; offy = 0;
    case (fc)
      FACE_PX: begin dx = one - a; dy = one;     dz = one - b; offx = 2 * f; offy = f; end
      FACE_NX: begin dx = a - one; dy = -one;    dz = one - b; offx = 0;     offy = f; end
      FACE_PY: begin dx = b - one; dy = a - one; dz = one;     offx = f;     offy = 0; end
      FACE_NY: begin dx = one - b; dy = a - one; dz = -one;    offx = f;     offy = 2 * f; end
      FACE_PZ: begin dx = -one;    dy = a - one; dz = b - one; offx = f;     offy = 3 * f; end
      FACE_NZ: begin dx = one;     dy = a - one; dz = one - b; offx = f;     offy = f; end
      default: ;  // unused codes: zero vector, no offset
    endcase
    pd = longint'(floor_sqrt(dx * dx + dy * dy));
    th = vec_angle(dy, dx);
    ph = vec_angle(dz, pd);
    if (th > pi) th = pi;
    if (th < -pi) th = -pi;
    if (ph > pi / 2) ph = pi / 2;
    if (ph < -pi / 2) ph = -pi / 2;
    uq = 2 * f * (th + pi);
    vq = 2 * f * (pi / 2 - ph);
    u0 = uq >> AngleBits;
    v0 = vq >> AngleBits;
    if (u0 > 4 * f - 1) u0 = 4 * f - 1;
    if (v0 > 2 * f - 1) v0 = 2 * f - 1;
    u1 = (u0 + 1 > 4 * f - 1) ? 4 * f - 1 : u0 + 1;
    v1 = (v0 + 1 > 2 * f - 1) ? 2 * f - 1 : v0 + 1;
    s.dest_x = 12'(offx + c);
    s.dest_y = 12'(offy + r);
    s.u0 = 12'(u0);
    s.v0 = 11'(v0);
    s.u1 = 12'(u1);
    s.v1 = 11'(v1);
    // angle has one more fraction bit than the weights: drop it
    s.fs = 17'((uq - (u0 <<< AngleBits)) >> (AngleBits - FracBits));
    s.ft = 17'((vq - (v0 <<< AngleBits)) >> (AngleBits - FracBits));
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Request monitor and result checker
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    n_fail++;
  endtask

  always @(posedge clk_i) begin
    sample_t want;
    cycles <= cycles + 1;
    if (rst_ni && start && !busy) begin
      pending_samples.push_back(predict_sample(face_i, col_i, row_i, edge_len));
      n_accepted++;
    end
    if (rst_ni && done_o) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected result, queue depth", 0, 0);
      end else begin
        want = pending_samples.pop_front();
        if (dest_x_o !== want.dest_x) report_mismatch("dest_x", dest_x_o, want.dest_x);
        if (dest_y_o !== want.dest_y) report_mismatch("dest_y", dest_y_o, want.dest_y);
        if (src_u0_o !== want.u0) report_mismatch("src_u0", src_u0_o, want.u0);
        if (src_v0_o !== want.v0) report_mismatch("src_v0", src_v0_o, want.v0);
        if (src_u1_o !== want.u1) report_mismatch("src_u1", src_u1_o, want.u1);
        if (src_v1_o !== want.v1) report_mismatch("src_v1", src_v1_o, want.v1);
        if (frac_s_o !== want.fs) report_mismatch("frac_s", frac_s_o, want.fs);
        if (frac_t_o !== want.ft) report_mismatch("frac_t", frac_t_o, want.ft);
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers (called right after a rising edge)
  // ---------------------------------------------------------------------------
  task automatic send_req(input logic [2:0] fc, input logic [9:0] c, input logic [9:0] r);
    int unsigned seen;
    // random idle cycles, ~10% of the time
    while (!no_idle && $urandom_range(99) < 10) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    seen = n_accepted;
    start <= 1'b1;
    face_i <= fc;
    col_i <= c;
    row_i <= r;
    @(posedge clk_i);
    wait (n_accepted != seen);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    wait (pending_samples.size() == 0);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  // write only with the pipeline empty
  task automatic write_edge_len(input logic [10:0] v);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= REG_EDGE_LEN; pwdata <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    edge_len = v;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // corners of every face code, including the two unused codes,
  // plus columns/rows past the face edge (coordinate saturation)
  task automatic test_face_corners();
    logic [9:0] pts[5];
    logic [9:0] f1;
    f1 = 10'(edge_len - 1);
    pts = '{10'd0, f1, 10'(edge_len / 2), 10'd1023, 10'(edge_len)};
    for (int fc = 0; fc < 8; fc++) begin
      send_req(3'(fc), pts[$urandom_range(4)], pts[$urandom_range(4)]);
      send_req(3'(fc), f1, f1);
      send_req(3'(fc), 10'd0, 10'd0);
    end
    send_req(FACE_PZ, 10'(edge_len / 2), 10'(edge_len / 2));  // theta near +-pi
    send_req(FACE_NY, 10'(edge_len / 2), 10'(edge_len / 2));  // phi near -pi/2
    drain();
  endtask

  task automatic test_random_pixels(input int n, input bit out_of_range);
    int unsigned f;
    logic [2:0] fc;
    f = (edge_len == 0) ? 1 : ((edge_len > MaxFaceSize) ? MaxFaceSize : edge_len);
    for (int i = 0; i < n; i++) begin
      // a long stretch with no idle cycles in the middle of each batch
      no_idle = (i > n / 3) && (i < n / 2);
      fc = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      if (out_of_range && $urandom_range(9) == 0)
        send_req(fc, 10'($urandom), 10'($urandom));
      else
        send_req(fc, 10'($urandom_range(f - 1)), 10'($urandom_range(f - 1)));
    end
    no_idle = 1'b0;
  endtask

  // sweep the edge length: extremes, zero, oversized, and random sizes
  task automatic test_edge_lens();
    logic [10:0] sizes[8];
    sizes = '{11'd1, 11'd1024, 11'd0, 11'd2047, 11'd3, 11'($urandom_range(1, 1024)),
              11'($urandom_range(1025, 2047)), 11'd256};
    foreach (sizes[k]) begin
      write_edge_len(sizes[k]);
      test_face_corners();
      test_random_pixels(200, 1'b1);
    end
  endtask

  // sender holds off until the pipeline is empty, then bursts
  task automatic test_drain_pause();
    test_random_pixels(60, 1'b0);
    drain();
    test_random_pixels(60, 1'b0);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_face_corners();     // reset value of the edge length
    test_edge_lens();
    test_drain_pause();
    start <= 1'b0;
    @(posedge clk_i);
    wait (pending_samples.size() == 0);
    repeat (PIPE_DRAIN) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
